// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Check that an implication holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

// File: hdl/mrmt_pkg.sv
// Shared types and constants of the memory region map table.
package mrmt_pkg;
   localparam int MaxEntries = 32;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);

   typedef enum logic [2:0] {
      ACT_LOAD = 3'd0, ACT_INSERT = 3'd1, ACT_MERGE = 3'd2,
      ACT_READ = 3'd3, ACT_TOTAL = 3'd4, ACT_SETTYPE = 3'd5,
      ACT_NONE6 = 3'd6, ACT_NONE7 = 3'd7
   } action_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BADIDX = 2'd2;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] length;
      logic [2:0]  kind;
      logic [31:0] acpi;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SORT_RD, S_SORT_KEY, S_SORT_CMP, S_MRG_RD, S_MRG_FIRST,
      S_MRG_STEP, S_MRG_END, S_TOT_RD, S_TOT_ACC, S_RD_WAIT, S_DONE
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic               latch_req;   // capture the request item
      logic               append;      // write request at count
      logic               set_kind;    // rewrite kind of the read entry
      logic [1:0]         rd_sel;      // 0 i, 1 j-1 (j-2 on a shift), 2 r, 3 index
      logic               rd_en;
      logic               sort_init;   // i <= 1
      logic               sort_take;   // read entry i as key, j <= i
      logic               sort_shift;  // write j-1 entry to j, j--
      logic               sort_place;  // write key at j, i++
      logic               mrg_init;
      logic               mrg_first;   // start run with read entry
      logic               mrg_add;     // add read entry to run
      logic               mrg_flush;   // write run at w, start new
      logic               mrg_final;   // write run, set count
      logic               tot_init;
      logic               tot_add;
      logic               rsp_load;    // load result register
      logic               cnt_inc;
   } cmd_type;

   typedef struct packed {
      action_type         action;
      logic               full;
      logic               idx_bad;
      logic               cnt_zero;
      logic               sort_more;   // i < count
      logic               sort_move;   // j>0 and mem[j-1].base > key
      logic               rd_more;     // r < count
      logic               kind_same;   // read kind equals run kind
   } sts_type;
endpackage

// File: hdl/mrmt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module mrmt_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end
   assign rd_data = rd_ff;
endmodule

// File: hdl/mrmt_ctrl.sv
// Controller state machine of the region map table.
`include "assert_macros.svh"
module mrmt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  mrmt_pkg::sts_type   sts,
   output mrmt_pkg::cmd_type   cmd
);
   mrmt_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrmt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   // Take a new item only in idle and when the result slot is free.
   assign req_tready = (state_ff == mrmt_pkg::S_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         mrmt_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.latch_req = 1'b1;
               state_in = mrmt_pkg::S_DONE;
            end
         end
         mrmt_pkg::S_DONE: begin
            // request is latched; dispatch on action
            unique case (sts.action)
               mrmt_pkg::ACT_LOAD: begin
                  if (!sts.full) begin
                     cmd.append = 1'b1;
                     cmd.cnt_inc = 1'b1;
                  end
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = mrmt_pkg::S_IDLE;
               end
               mrmt_pkg::ACT_INSERT: begin
                  if (sts.full) begin
                     cmd.rsp_load = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in = mrmt_pkg::S_IDLE;
                  end else begin
                     cmd.append = 1'b1;
                     cmd.cnt_inc = 1'b1;
                     cmd.sort_init = 1'b1;
                     state_in = mrmt_pkg::S_SORT_RD;
                  end
               end
               mrmt_pkg::ACT_MERGE: begin
                  cmd.mrg_init = 1'b1;
                  if (sts.cnt_zero) begin
                     cmd.rsp_load = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in = mrmt_pkg::S_IDLE;
                  end else begin
                     state_in = mrmt_pkg::S_MRG_RD;
                  end
               end
               mrmt_pkg::ACT_READ, mrmt_pkg::ACT_SETTYPE: begin
                  if (sts.idx_bad) begin
                     cmd.rsp_load = 1'b1;
                     rsp_valid_in = 1'b1;
                     state_in = mrmt_pkg::S_IDLE;
                  end else begin
                     cmd.rd_en = 1'b1;
                     cmd.rd_sel = 2'd3;
                     state_in = mrmt_pkg::S_RD_WAIT;
                  end
               end
               mrmt_pkg::ACT_TOTAL: begin
                  cmd.tot_init = 1'b1;
                  state_in = mrmt_pkg::S_TOT_RD;
               end
               default: begin
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = mrmt_pkg::S_IDLE;
               end
            endcase
         end
         mrmt_pkg::S_SORT_RD: begin
            // read entry i as the key (i counts from 1)
            if (sts.sort_more) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd0;
               cmd.sort_take = 1'b1;
               state_in = mrmt_pkg::S_SORT_KEY;
            end else begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = mrmt_pkg::S_IDLE;
            end
         end
         mrmt_pkg::S_SORT_KEY: begin
            // key lands this cycle; start reading entry j-1
            cmd.rd_en = 1'b1;
            cmd.rd_sel = 2'd1;
            state_in = mrmt_pkg::S_SORT_CMP;
         end
         mrmt_pkg::S_SORT_CMP: begin
            // rd data holds entry j-1
            if (sts.sort_move) begin
               cmd.sort_shift = 1'b1;
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd1;
            end else begin
               cmd.sort_place = 1'b1;
               state_in = mrmt_pkg::S_SORT_RD;
            end
         end
         mrmt_pkg::S_MRG_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = 2'd2;
            state_in = mrmt_pkg::S_MRG_FIRST;
         end
         mrmt_pkg::S_MRG_FIRST: begin
            cmd.mrg_first = 1'b1;
            if (sts.rd_more) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd2;
               state_in = mrmt_pkg::S_MRG_STEP;
            end else begin
               state_in = mrmt_pkg::S_MRG_END;
            end
         end
         mrmt_pkg::S_MRG_STEP: begin
            if (sts.kind_same) cmd.mrg_add = 1'b1;
            else cmd.mrg_flush = 1'b1;
            if (sts.rd_more) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd2;
            end else begin
               state_in = mrmt_pkg::S_MRG_END;
            end
         end
         mrmt_pkg::S_MRG_END: begin
            cmd.mrg_final = 1'b1;
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = mrmt_pkg::S_IDLE;
         end
         mrmt_pkg::S_TOT_RD: begin
            if (sts.rd_more) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd2;
               state_in = mrmt_pkg::S_TOT_ACC;
            end else begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = mrmt_pkg::S_IDLE;
            end
         end
         mrmt_pkg::S_TOT_ACC: begin
            cmd.tot_add = 1'b1;
            if (sts.rd_more) begin
               cmd.rd_en = 1'b1;
               cmd.rd_sel = 2'd2;
            end else begin
               state_in = mrmt_pkg::S_TOT_RD;
            end
         end
         mrmt_pkg::S_RD_WAIT: begin
            cmd.set_kind = (sts.action == mrmt_pkg::ACT_SETTYPE);
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = mrmt_pkg::S_IDLE;
         end
         default: state_in = mrmt_pkg::S_IDLE;
      endcase
   end

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_tready,
      state_ff == mrmt_pkg::S_IDLE, "ready outside idle")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid, "result dropped while stalled")
   `ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready,
      !req_tready, "second item taken before result")
endmodule

// File: hdl/mrmt_dpath.sv
// Datapath of the region map table: entry memory, pointers, accumulators.
`include "assert_macros.svh"
module mrmt_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_action,
   input  logic [4:0]          req_index,
   input  logic [63:0]         req_base,
   input  logic [63:0]         req_length,
   input  logic [2:0]          req_kind,
   input  logic [31:0]         req_acpi,
   input  mrmt_pkg::cmd_type   cmd,
   output mrmt_pkg::sts_type   sts,
   output logic [1:0]          rsp_status,
   output mrmt_pkg::entry_type rsp_entry,
   output logic [5:0]          rsp_count,
   output logic [31:0]         rsp_total
);
   localparam int EW = $bits(mrmt_pkg::entry_type);
   localparam int IW = mrmt_pkg::IdxW;
   localparam int CW = mrmt_pkg::CntW;

   mrmt_pkg::action_type act_ff;
   logic [4:0]  idx_ff;
   mrmt_pkg::entry_type reqe_ff;
   logic        full_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, j_ff, r_ff, w_ff;
   mrmt_pkg::entry_type key_ff, run_ff;
   logic [31:0] tot_ff;
   logic        key_pend_ff;
   logic [1:0]  st_ff;
   mrmt_pkg::entry_type oe_ff;
   logic [5:0]  oc_ff;
   logic [31:0] ot_ff;

   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   mrmt_pkg::entry_type wr_data, rd_data;
   logic [EW-1:0] rd_raw;

   mrmt_ram #(.Width(EW), .Depth(mrmt_pkg::MaxEntries)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_raw)
   );
   assign rd_data = rd_raw;

   logic idx_bad;
   assign idx_bad = {1'b0, idx_ff} >= 6'(cnt_ff) ||
                    {1'b0, idx_ff} >= 6'(mrmt_pkg::MaxEntries);

   always_comb begin
      sts.action    = act_ff;
      sts.full      = cnt_ff == CW'(mrmt_pkg::MaxEntries);
      sts.idx_bad   = idx_bad;
      sts.cnt_zero  = cnt_ff == '0;
      sts.sort_more = i_ff < cnt_ff;
      // key_pend: rd_data holds the key itself this cycle
      sts.sort_move = !key_pend_ff && j_ff != '0 && rd_data.base > key_ff.base;
      sts.rd_more   = r_ff < cnt_ff;
      sts.kind_same = rd_data.kind == run_ff.kind;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      if (cmd.append) begin
         wr_en = 1'b1;
         wr_addr = cnt_ff[IW-1:0];
         wr_data = reqe_ff;
         if (act_ff == mrmt_pkg::ACT_INSERT) wr_data.acpi = '0;
      end else if (cmd.set_kind) begin
         wr_en = 1'b1;
         wr_addr = idx_ff[IW-1:0];
         wr_data = rd_data;
         wr_data.kind = reqe_ff.kind;
      end else if (cmd.sort_shift) begin
         wr_en = 1'b1;
         wr_addr = j_ff[IW-1:0];
         wr_data = rd_data;
      end else if (cmd.sort_place) begin
         wr_en = 1'b1;
         wr_addr = j_ff[IW-1:0];
         wr_data = key_ff;
      end else if (cmd.mrg_flush || cmd.mrg_final) begin
         wr_en = 1'b1;
         wr_addr = w_ff[IW-1:0];
         wr_data = run_ff;
      end
   end

   // Set type rewrites the entry read at the index with the new kind.

   always_comb begin
      rd_en = cmd.rd_en;
      unique case (cmd.rd_sel)
         2'd0: rd_addr = i_ff[IW-1:0];
         2'd1: rd_addr = IW'(j_ff - CW'(cmd.sort_shift ? 2 : 1));
         2'd2: rd_addr = r_ff[IW-1:0];
         default: rd_addr = idx_ff[IW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         key_pend_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         key_pend_ff <= cmd.sort_take;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_inc) cnt_in = cnt_ff + CW'(1);
      if (cmd.mrg_final) cnt_in = w_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         act_ff <= mrmt_pkg::action_type'(req_action);
         idx_ff <= req_index;
         reqe_ff <= '{base: req_base, length: req_length, kind: req_kind,
                      acpi: req_acpi};
         full_ff <= sts.full;
      end
      if (cmd.sort_init) i_ff <= CW'(1);
      // first cycle after take: rd_data is the key
      if (key_pend_ff) begin
         key_ff <= rd_data;
      end
      if (cmd.sort_take) j_ff <= i_ff;
      if (cmd.sort_shift) j_ff <= j_ff - CW'(1);
      if (cmd.sort_place) i_ff <= i_ff + CW'(1);
      if (cmd.mrg_init || cmd.tot_init) begin
         r_ff <= '0;
         w_ff <= '0;
         tot_ff <= '0;
      end
      if (cmd.rd_en && cmd.rd_sel == 2'd2) r_ff <= r_ff + CW'(1);
      // a run starts with the entry on the read port
      if (cmd.mrg_first || cmd.mrg_flush) run_ff <= rd_data;
      if (cmd.mrg_add) run_ff.length <= run_ff.length + rd_data.length;
      if (cmd.mrg_flush) w_ff <= w_ff + CW'(1);
      if (cmd.tot_add) tot_ff <= tot_ff + rd_data.length[31:0];
      if (cmd.rsp_load) begin
         oc_ff <= 6'(cnt_in);
         if ((act_ff == mrmt_pkg::ACT_LOAD || act_ff == mrmt_pkg::ACT_INSERT)
             && full_ff) begin
            st_ff <= mrmt_pkg::ST_FULL;
         end else if ((act_ff == mrmt_pkg::ACT_READ ||
                       act_ff == mrmt_pkg::ACT_SETTYPE) && idx_bad) begin
            st_ff <= mrmt_pkg::ST_BADIDX;
         end else begin
            st_ff <= mrmt_pkg::ST_OK;
         end
         if (act_ff == mrmt_pkg::ACT_READ && !idx_bad) oe_ff <= rd_data;
         else oe_ff <= '0;
         if (act_ff == mrmt_pkg::ACT_TOTAL) ot_ff <= tot_ff;
         else ot_ff <= '0;
      end
   end

   assign rsp_status = st_ff;
   assign rsp_entry  = oe_ff;
   assign rsp_count  = oc_ff;
   assign rsp_total  = ot_ff;

   `ASSERT_IMPL(a_cnt_max, clock, reset, 1'b1,
      cnt_ff <= CW'(mrmt_pkg::MaxEntries), "count above table size")
   `ASSERT_IMPL(a_one_write, clock, reset, cmd.append,
      !cmd.sort_shift && !cmd.mrg_flush, "two write sources")
endmodule

// File: hdl/memory_region_map_table.sv
// Top level of the memory region map table.
// Keeps up to 32 memory regions (base, length, type, ACPI word) in one RAM.
// Input channel req_*: one action item; output channel rsp_*: one result
// item for every accepted item, in order.
// Load, unknown actions, a full table and a bad index are answered from the
// dispatch state; read and set type first wait for the RAM read.
// Insert runs a stable insertion sort through the single RAM read port,
// reading each key and shifting larger entries up one at a time. Merge and
// total walk the table once.
// One item is in work at a time; the next item is taken in the cycle after
// the result has been handed over.
// Reset clears the entry count; the table memory is not cleared.
// A stalled receiver holds the result in the output register and holds off
// the next item.
module memory_region_map_table (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // action[2:0], entry_index[7:3], region_base[71:8], region_length[135:72],
   // region_kind[138:136], acpi_word[170:139], zero fill to 176
   input  logic [175:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[1:0], out_base[65:2], out_length[129:66], out_kind[132:130],
   // out_acpi[164:133], count_now[170:165], total_bytes[202:171], fill to 208
   output logic [207:0]  rsp_tdata
);
   mrmt_pkg::cmd_type   cmd;
   mrmt_pkg::sts_type   sts;
   mrmt_pkg::entry_type ent;
   logic [1:0]  st;
   logic [5:0]  cnt;
   logic [31:0] tot;

   mrmt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .sts(sts), .cmd(cmd)
   );

   mrmt_dpath u_dpath (
      .clock(clock), .reset(reset),
      .req_action(req_tdata[2:0]), .req_index(req_tdata[7:3]),
      .req_base(req_tdata[71:8]), .req_length(req_tdata[135:72]),
      .req_kind(req_tdata[138:136]), .req_acpi(req_tdata[170:139]),
      .cmd(cmd), .sts(sts), .rsp_status(st), .rsp_entry(ent),
      .rsp_count(cnt), .rsp_total(tot)
   );

   assign rsp_tdata = {5'd0, tot, cnt, ent.acpi, ent.kind, ent.length,
                       ent.base, st};
endmodule
